@@ hw/rtl/fsba_pkg.sv @@
// shared constants, codes and record types of the fixed-size block allocator
package fsba_pkg;

    // pool geometry; the widths of the page and index fields follow from it
    localparam int unsigned MAX_PAGES  = 16;
    localparam int unsigned MAX_BLOCKS = 1024;
    localparam int unsigned PAGE_W     = $clog2(MAX_PAGES);
    localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam int unsigned STORE_AW   = PAGE_W + IDX_W;
    localparam int unsigned STATUS_W   = 2;

    // end of a free list, and blocks per page after reset
    localparam logic [CNT_W-1:0] END_MARK  = '1;
    localparam logic [CNT_W-1:0] BPP_RESET = CNT_W'(MAX_BLOCKS);

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd2;

    // one page record: free list head, initialised count and ring links
    typedef struct packed {
        logic [CNT_W-1:0]  cursor;
        logic [CNT_W-1:0]  init_cnt;
        logic [PAGE_W-1:0] nxt;
        logic [PAGE_W-1:0] prv;
    } t_page;

    // write port of the page table
    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] addr;
        t_page             data;
    } t_page_wr;

    // write port of the next-free store
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [CNT_W-1:0]    data;
    } t_store_wr;

endpackage

@@ hw/rtl/fsba_intf.sv @@
// request and response channel interfaces of the block allocator

interface fsba_req_if;
    import fsba_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [PAGE_W-1:0] free_page;
    logic [IDX_W-1:0]  free_index;

    modport source (output valid, op, free_page, free_index, input ready);
    modport sink   (input valid, op, free_page, free_index, output ready);
endinterface

interface fsba_rsp_if;
    import fsba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   block_page;
    logic [IDX_W-1:0]    block_index;

    modport source (output valid, status, block_page, block_index, input ready);
    modport sink   (input valid, status, block_page, block_index, output ready);
endinterface

@@ hw/rtl/fixed_size_block_allocator.sv @@
// fixed-size block allocator top level: configuration register, memories, sequencer
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        op, free_page, free_index
//  o_rsp     out  valid/ready        status, block_page, block_index
//  i_cfg     in   i_cfg_we           i_cfg_wdata (blocks per page)
//
// an alloc does the page table read, the next-free store read and the write back
// through one port of each memory in turn, a free the page table read and write back
// an alloc that finds its page full walks the ring one page a cycle (at most 16),
// then reads the cursor block of the page it lands on
// linking in a fresh page writes its record, then relinks the current page and, when the
// ring already holds several pages, the previous one
// an alloc that fills its page walks on the same way after its block is handed out,
// without reading a cursor block
// after reset the first page record is written before an item is taken; a result waiting
// in the output register holds back only the next result, not the next item

module fixed_size_block_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fsba_req_if.sink                   i_req,
    fsba_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [fsba_pkg::CNT_W-1:0] i_cfg_wdata
);
    import fsba_pkg::*;

    logic [CNT_W-1:0]    r_bpp;
    logic [CNT_W-1:0]    bpp_eff;
    t_page_wr            page_wr;
    logic [PAGE_W-1:0]   page_raddr;
    t_page               page_rdata;
    t_store_wr           store_wr;
    logic [STORE_AW-1:0] store_raddr;
    logic [CNT_W-1:0]    store_rdata;

    // blocks per page register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_RESET;
        end else if (i_cfg_we) begin
            r_bpp <= i_cfg_wdata;
        end
    end

    // zero acts as one, above the pool width acts as the full page
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = CNT_W'(1);
        end else if (r_bpp > CNT_W'(MAX_BLOCKS)) begin
            bpp_eff = CNT_W'(MAX_BLOCKS);
        end else begin
            bpp_eff = r_bpp;
        end
    end

    fsba_page_mem u_page_mem (
        .i_clk   (i_clk),
        .i_wr    (page_wr),
        .i_raddr (page_raddr),
        .o_rdata (page_rdata)
    );

    fsba_store_mem u_store_mem (
        .i_clk   (i_clk),
        .i_wr    (store_wr),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    fsba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .i_bpp         (bpp_eff),
        .o_page_wr     (page_wr),
        .o_page_raddr  (page_raddr),
        .i_page_rdata  (page_rdata),
        .o_store_wr    (store_wr),
        .o_store_raddr (store_raddr),
        .i_store_rdata (store_rdata)
    );

endmodule

@@ hw/rtl/fsba_store_mem.sv @@
// next-free store: one link word per block of every page, registered read
module fsba_store_mem (
    input  logic                          i_clk,
    input  fsba_pkg::t_store_wr           i_wr,
    input  logic [fsba_pkg::STORE_AW-1:0] i_raddr,
    output logic [fsba_pkg::CNT_W-1:0]    o_rdata
);
    import fsba_pkg::*;

    logic [CNT_W-1:0] r_mem [(1 << STORE_AW)];
    logic [CNT_W-1:0] r_rdata;

    // one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fsba_page_mem.sv @@
// page table: one record per page, registered read
module fsba_page_mem (
    input  logic                        i_clk,
    input  fsba_pkg::t_page_wr          i_wr,
    input  logic [fsba_pkg::PAGE_W-1:0] i_raddr,
    output fsba_pkg::t_page             o_rdata
);
    import fsba_pkg::*;

    t_page r_mem [MAX_PAGES];
    t_page r_rdata;

    // one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fsba_ctrl.sv @@
// allocator sequencer: alloc and free read-modify-write, ring walk, page linking
module fsba_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fsba_req_if.sink                      i_req,
    fsba_rsp_if.source                    o_rsp,
    input  logic [fsba_pkg::CNT_W-1:0]    i_bpp,
    output fsba_pkg::t_page_wr            o_page_wr,
    output logic [fsba_pkg::PAGE_W-1:0]   o_page_raddr,
    input  fsba_pkg::t_page               i_page_rdata,
    output fsba_pkg::t_store_wr           o_store_wr,
    output logic [fsba_pkg::STORE_AW-1:0] o_store_raddr,
    input  logic [fsba_pkg::CNT_W-1:0]    i_store_rdata
);
    import fsba_pkg::*;

    localparam int unsigned STATE_W = 4;
    localparam logic [STATE_W-1:0] S_INIT  = 4'd0;
    localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
    localparam logic [STATE_W-1:0] S_ACHK  = 4'd2;
    localparam logic [STATE_W-1:0] S_ALOOK = 4'd3;
    localparam logic [STATE_W-1:0] S_AUPD  = 4'd4;
    localparam logic [STATE_W-1:0] S_SRCH  = 4'd5;
    localparam logic [STATE_W-1:0] S_INS1  = 4'd6;
    localparam logic [STATE_W-1:0] S_INS2  = 4'd7;
    localparam logic [STATE_W-1:0] S_INS3  = 4'd8;
    localparam logic [STATE_W-1:0] S_FUPD  = 4'd9;
    localparam logic [STATE_W-1:0] S_DONE  = 4'd10;

    logic [STATE_W-1:0]   r_state,   n_state;
    logic [PAGE_W-1:0]    r_cur,     n_cur;
    logic [PAGE_W:0]      r_pages,   n_pages;
    logic [MAX_PAGES-1:0] r_active,  n_active;
    t_page                r_rec,     n_rec;
    logic [PAGE_W-1:0]    r_s,       n_s;
    logic [PAGE_W-1:0]    r_new,     n_new;
    logic                 r_post,    n_post;
    logic [PAGE_W-1:0]    r_fp,      n_fp;
    logic [IDX_W-1:0]     r_fi,      n_fi;
    logic [STATUS_W-1:0]  r_rstatus, n_rstatus;
    logic [PAGE_W-1:0]    r_rpage,   n_rpage;
    logic [IDX_W-1:0]     r_ridx,    n_ridx;
    logic                 r_ovalid,  n_ovalid;
    logic [STATUS_W-1:0]  r_ostatus, n_ostatus;
    logic [PAGE_W-1:0]    r_opage,   n_opage;
    logic [IDX_W-1:0]     r_oidx,    n_oidx;

    logic [PAGE_W-1:0]    free_pg;
    t_page                fresh_rec;
    t_page                boot_rec;
    t_page                upd;
    logic                 ins_done;

    // lowest page not on the ring
    always_comb begin
        free_pg = '0;
        for (int k = MAX_PAGES - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                free_pg = PAGE_W'(k);
            end
        end
    end

    // record of a page linked in just before the current one
    always_comb begin
        fresh_rec          = '0;
        fresh_rec.init_cnt = CNT_W'(1);
        fresh_rec.nxt      = r_cur;
        fresh_rec.prv      = r_rec.prv;
    end

    // record of page 0 after reset: a ring of one
    always_comb begin
        boot_rec          = '0;
        boot_rec.init_cnt = CNT_W'(1);
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_pages   = r_pages;
        n_active  = r_active;
        n_rec     = r_rec;
        n_s       = r_s;
        n_new     = r_new;
        n_post    = r_post;
        n_fp      = r_fp;
        n_fi      = r_fi;
        n_rstatus = r_rstatus;
        n_rpage   = r_rpage;
        n_ridx    = r_ridx;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_opage   = r_opage;
        n_oidx    = r_oidx;

        o_page_raddr  = r_cur;
        o_store_raddr = '0;
        o_page_wr     = '0;
        o_store_wr    = '0;
        upd           = r_rec;
        ins_done      = 1'b0;

        // result register drains when taken
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // write the end marker of page 0 block 0 and the page 0 record
            S_INIT: begin
                o_store_wr.en   = 1'b1;
                o_store_wr.addr = '0;
                o_store_wr.data = END_MARK;
                o_page_wr.en    = 1'b1;
                o_page_wr.addr  = '0;
                o_page_wr.data  = boot_rec;
                n_state         = S_IDLE;
            end

            // page record read starts with the accepted item
            S_IDLE: begin
                o_page_raddr = (i_req.op == OP_FREE) ? i_req.free_page : r_cur;
                if (i_req.valid) begin
                    n_fp   = i_req.free_page;
                    n_fi   = i_req.free_index;
                    n_post = 1'b0;
                    n_state = (i_req.op == OP_FREE) ? S_FUPD : S_ACHK;
                end
            end

            // current page full: walk the ring, else read the cursor block
            S_ACHK: begin
                n_rec = i_page_rdata;
                if (i_page_rdata.cursor >= i_bpp) begin
                    o_page_raddr = i_page_rdata.nxt;
                    n_s          = i_page_rdata.nxt;
                    n_state      = S_SRCH;
                end else begin
                    o_store_raddr = {r_cur, i_page_rdata.cursor[IDX_W-1:0]};
                    n_state       = S_AUPD;
                end
            end

            // page chosen after a walk or a link: read its cursor block
            S_ALOOK: begin
                o_store_raddr = {r_cur, r_rec.cursor[IDX_W-1:0]};
                n_state       = S_AUPD;
            end

            // hand out the cursor block, advance the cursor, and walk on when the page fills
            S_AUPD: begin
                n_rstatus = ST_OK;
                n_rpage   = r_cur;
                n_ridx    = r_rec.cursor[IDX_W-1:0];
                n_state   = S_DONE;
                if (i_store_rdata == END_MARK) begin
                    if (r_rec.init_cnt >= i_bpp) begin
                        upd.cursor   = i_bpp;
                        o_page_raddr = r_rec.nxt;
                        n_s          = r_rec.nxt;
                        n_post       = 1'b1;
                        n_state      = S_SRCH;
                    end else begin
                        upd.cursor      = r_rec.init_cnt;
                        upd.init_cnt    = r_rec.init_cnt + CNT_W'(1);
                        o_store_wr.en   = 1'b1;
                        o_store_wr.addr = {r_cur, r_rec.init_cnt[IDX_W-1:0]};
                        o_store_wr.data = END_MARK;
                    end
                end else begin
                    upd.cursor = i_store_rdata;
                end
                o_page_wr.en   = 1'b1;
                o_page_wr.addr = r_cur;
                o_page_wr.data = upd;
                n_rec          = upd;
            end

            // one ring page a cycle; back at the current page means all full
            S_SRCH: begin
                if (r_s == r_cur) begin
                    if (r_pages < (PAGE_W + 1)'(MAX_PAGES)) begin
                        n_state = S_INS1;
                    end else if (r_post) begin
                        n_state = S_DONE;
                    end else begin
                        n_rstatus = ST_NOMEM;
                        n_rpage   = '0;
                        n_ridx    = '0;
                        n_state   = S_DONE;
                    end
                end else if (i_page_rdata.cursor < i_bpp) begin
                    n_cur   = r_s;
                    n_rec   = i_page_rdata;
                    n_state = r_post ? S_DONE : S_ALOOK;
                end else begin
                    o_page_raddr = i_page_rdata.nxt;
                    n_s          = i_page_rdata.nxt;
                end
            end

            // new page record and its first block
            S_INS1: begin
                o_page_wr.en      = 1'b1;
                o_page_wr.addr    = free_pg;
                o_page_wr.data    = fresh_rec;
                o_store_wr.en     = 1'b1;
                o_store_wr.addr   = {free_pg, IDX_W'(0)};
                o_store_wr.data   = END_MARK;
                n_active[free_pg] = 1'b1;
                n_new             = free_pg;
                n_pages           = r_pages + (PAGE_W + 1)'(1);
                n_state           = S_INS2;
            end

            // relink the current page, fetch the previous one
            S_INS2: begin
                upd.prv = r_new;
                if (r_rec.prv == r_cur) begin
                    upd.nxt  = r_new;
                    ins_done = 1'b1;
                end else begin
                    n_state = S_INS3;
                end
                o_page_wr.en   = 1'b1;
                o_page_wr.addr = r_cur;
                o_page_wr.data = upd;
                o_page_raddr   = r_rec.prv;
            end

            // relink the previous page
            S_INS3: begin
                upd            = i_page_rdata;
                upd.nxt        = r_new;
                o_page_wr.en   = 1'b1;
                o_page_wr.addr = r_rec.prv;
                o_page_wr.data = upd;
                ins_done       = 1'b1;
            end

            // push the block onto its page's free list, or reject it for an inactive page or an out-of-range index
            S_FUPD: begin
                n_rpage = '0;
                n_ridx  = '0;
                n_state = S_DONE;
                if (r_active[r_fp] && ({1'b0, r_fi} < i_bpp)) begin
                    n_rstatus       = ST_OK;
                    n_cur           = r_fp;
                    o_store_wr.en   = 1'b1;
                    o_store_wr.addr = {r_fp, r_fi};
                    o_store_wr.data = (i_page_rdata.cursor >= i_bpp) ? END_MARK
                                                                     : i_page_rdata.cursor;
                    upd             = i_page_rdata;
                    upd.cursor      = CNT_W'(r_fi);
                    o_page_wr.en    = 1'b1;
                    o_page_wr.addr  = r_fp;
                    o_page_wr.data  = upd;
                end else begin
                    n_rstatus = ST_REJECT;
                end
            end

            // move the result into the output register once it is free
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rstatus;
                    n_opage   = r_rpage;
                    n_oidx    = r_ridx;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new page becomes current
        if (ins_done) begin
            n_cur   = r_new;
            n_rec   = fresh_rec;
            n_state = r_post ? S_DONE : S_ALOOK;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cur    <= '0;
            r_pages  <= (PAGE_W + 1)'(1);
            r_active <= MAX_PAGES'(1);
            r_post   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_pages  <= n_pages;
            r_active <= n_active;
            r_post   <= n_post;
            r_ovalid <= n_ovalid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_rec     <= n_rec;
        r_s       <= n_s;
        r_new     <= n_new;
        r_fp      <= n_fp;
        r_fi      <= n_fi;
        r_rstatus <= n_rstatus;
        r_rpage   <= n_rpage;
        r_ridx    <= n_ridx;
        r_ostatus <= n_ostatus;
        r_opage   <= n_opage;
        r_oidx    <= n_oidx;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.block_page  = r_opage;
    assign o_rsp.block_index = r_oidx;

    // page count follows the ring membership
    a_pages_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages == ($countones(r_active) & 32'h3f))
        else $error("page count differs from active pages");

    // current page always on the ring
    a_cur_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active[r_cur])
        else $error("current page not active");

    // the ring walk only visits linked pages
    a_walk_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> r_active[r_s])
        else $error("ring walk reached an inactive page");

    // a finished item is shown the cycle after its slot frees
    a_done_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || o_rsp.ready)) |=>
            (r_ovalid && r_state == S_IDLE))
        else $error("finished item not loaded into output register");

endmodule
